// ===== design/dpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpm_pkg
// Types, constants and field widths shared by the binary64 multiplier.
// ----------------------------------------------------------------------------
package dpm_pkg;

    localparam int WORD_W  = 64;
    localparam int EXP_W   = 11;
    localparam int FRAC_W  = 52;
    localparam int SIG_W   = FRAC_W + 1;
    localparam int PROD_W  = 2 * SIG_W;
    localparam int ESUM_W  = EXP_W + 2;
    localparam int LO_W    = 27;
    localparam int HI_W    = SIG_W - LO_W;

    localparam logic [EXP_W-1:0]  EXP_MAX    = '1;
    localparam logic [ESUM_W-1:0] EXP_BIAS   = ESUM_W'(1023);
    localparam logic [ESUM_W-1:0] EXP_LIMIT  = ESUM_W'(2047);
    localparam logic [WORD_W-1:0] QUIET_BIT  = 64'h0008_0000_0000_0000;
    localparam logic [WORD_W-1:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;

    // Side information that travels with each request down the pipeline.
    typedef struct packed {
        logic                     sign;
        logic signed [ESUM_W-1:0] exp_sum;
        logic                     special;
        logic [WORD_W-1:0]        special_val;
    } t_meta;

endpackage

// ===== design/dpm_unpack.sv =====
// ----------------------------------------------------------------------------
// dpm_unpack
// First stage: splits the operands, resolves NaN, infinity and zero cases.
// ----------------------------------------------------------------------------
module dpm_unpack
    import dpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_vld,
    output t_meta             o_meta,
    output logic [SIG_W-1:0]  o_ma,
    output logic [SIG_W-1:0]  o_mb
);

    logic [EXP_W-1:0]  ea, eb;
    logic [FRAC_W-1:0] fa, fb;
    logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sign;
    t_meta             n_meta;
    logic              r_vld;
    t_meta             r_meta;
    logic [SIG_W-1:0]  r_ma, r_mb;

    // Field decode and special-case selection.
    always_comb begin
        ea     = i_a[WORD_W-2 -: EXP_W];
        eb     = i_b[WORD_W-2 -: EXP_W];
        fa     = i_a[FRAC_W-1:0];
        fb     = i_b[FRAC_W-1:0];
        sign   = i_a[WORD_W-1] ^ i_b[WORD_W-1];
        nan_a  = (ea == EXP_MAX) && (fa != '0);
        nan_b  = (eb == EXP_MAX) && (fb != '0);
        inf_a  = (ea == EXP_MAX) && (fa == '0);
        inf_b  = (eb == EXP_MAX) && (fb == '0);
        zero_a = (ea == '0);
        zero_b = (eb == '0);
        n_meta.sign    = sign;
        n_meta.exp_sum = $signed(ESUM_W'(ea) + ESUM_W'(eb) - EXP_BIAS);
        n_meta.special = 1'b1;
        if (nan_a) begin
            n_meta.special_val = i_a | QUIET_BIT;
        end else if (nan_b) begin
            n_meta.special_val = i_b | QUIET_BIT;
        end else if ((inf_a && zero_b) || (inf_b && zero_a)) begin
            n_meta.special_val = DEFAULT_NAN;
        end else if (inf_a || inf_b) begin
            n_meta.special_val = {sign, EXP_MAX, {FRAC_W{1'b0}}};
        end else if (zero_a || zero_b) begin
            n_meta.special_val = {sign, {(WORD_W-1){1'b0}}};
        end else begin
            n_meta.special     = 1'b0;
            n_meta.special_val = '0;
        end
    end

    // Valid bit with reset; payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= n_meta;
        r_ma   <= {1'b1, fa};
        r_mb   <= {1'b1, fb};
    end

    assign o_vld  = r_vld;
    assign o_meta = r_meta;
    assign o_ma   = r_ma;
    assign o_mb   = r_mb;

endmodule

// ===== design/dpm_mul.sv =====
// ----------------------------------------------------------------------------
// dpm_mul
// Two stages: four partial products of at most 27x27 bits, then their sum.
// ----------------------------------------------------------------------------
module dpm_mul
    import dpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_meta             i_meta,
    input  logic [SIG_W-1:0]  i_ma,
    input  logic [SIG_W-1:0]  i_mb,
    output logic              o_vld,
    output t_meta             o_meta,
    output logic [PROD_W-1:0] o_prod
);

    logic [1:0]               r_vld;
    t_meta                    r_meta0, r_meta1;
    logic [2*LO_W-1:0]        r_pp_ll;
    logic [LO_W+HI_W-1:0]     r_pp_lh, r_pp_hl;
    logic [2*HI_W-1:0]        r_pp_hh;
    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W-1:0]        n_prod;

    // Sum of the partial products at their weights.
    always_comb begin
        n_prod = (PROD_W'(r_pp_hh) << (2*LO_W))
               + ((PROD_W'(r_pp_lh) + PROD_W'(r_pp_hl)) << LO_W)
               + PROD_W'(r_pp_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    // Partial products, then the full product.
    always_ff @(posedge i_clk) begin
        r_pp_ll <= i_ma[LO_W-1:0] * i_mb[LO_W-1:0];
        r_pp_lh <= i_ma[LO_W-1:0] * i_mb[SIG_W-1:LO_W];
        r_pp_hl <= i_ma[SIG_W-1:LO_W] * i_mb[LO_W-1:0];
        r_pp_hh <= i_ma[SIG_W-1:LO_W] * i_mb[SIG_W-1:LO_W];
        r_meta0 <= i_meta;
        r_prod  <= n_prod;
        r_meta1 <= r_meta0;
    end

    assign o_vld  = r_vld[1];
    assign o_meta = r_meta1;
    assign o_prod = r_prod;

endmodule

// ===== design/dpm_round.sv =====
// ----------------------------------------------------------------------------
// dpm_round
// Two stages: normalize with guard and sticky, then round, range check, pack.
// ----------------------------------------------------------------------------
module dpm_round
    import dpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_meta             i_meta,
    input  logic [PROD_W-1:0] i_prod,
    output logic              o_vld,
    output logic [WORD_W-1:0] o_product,
    output logic              o_ovf,
    output logic              o_unf
);

    logic                     norm;
    logic [SIG_W-1:0]         n_mant;
    logic                     guard, sticky;
    logic                     n_rnd;
    logic [SIG_W:0]           rsum;
    logic signed [ESUM_W-1:0] efin;
    logic [WORD_W-1:0]        n_product;
    logic                     n_ovf, n_unf;

    logic                     r_vld_c, r_vld_d;
    t_meta                    r_meta;
    logic [SIG_W-1:0]         r_mant;
    logic                     r_rnd;
    logic [WORD_W-1:0]        r_product;
    logic                     r_ovf, r_unf;

    // Normalization by one bit and round-to-nearest-even decision.
    always_comb begin
        norm   = i_prod[PROD_W-1];
        n_mant = norm ? i_prod[PROD_W-1 -: SIG_W] : i_prod[PROD_W-2 -: SIG_W];
        guard  = norm ? i_prod[FRAC_W] : i_prod[FRAC_W-1];
        sticky = norm ? (i_prod[FRAC_W-1:0] != '0) : (i_prod[FRAC_W-2:0] != '0);
        n_rnd  = guard && (sticky || n_mant[0]);
    end

    // Rounding, carry renormalization and range check.
    always_comb begin
        rsum      = {1'b0, r_mant} + (SIG_W+1)'(r_rnd);
        efin      = r_meta.exp_sum + $signed(ESUM_W'(rsum[SIG_W]));
        n_ovf     = 1'b0;
        n_unf     = 1'b0;
        if (r_meta.special) begin
            n_product = r_meta.special_val;
        end else if (efin >= $signed(EXP_LIMIT)) begin
            n_product = {r_meta.sign, EXP_MAX, {FRAC_W{1'b0}}};
            n_ovf     = 1'b1;
        end else if (efin <= $signed(ESUM_W'(0))) begin
            n_product = {r_meta.sign, {(WORD_W-1){1'b0}}};
            n_unf     = 1'b1;
        end else if (rsum[SIG_W]) begin
            n_product = {r_meta.sign, efin[EXP_W-1:0], rsum[FRAC_W:1]};
        end else begin
            n_product = {r_meta.sign, efin[EXP_W-1:0], rsum[FRAC_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            r_vld_c <= i_vld;
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta.sign        <= i_meta.sign;
        r_meta.exp_sum     <= i_meta.exp_sum + $signed(ESUM_W'(norm));
        r_meta.special     <= i_meta.special;
        r_meta.special_val <= i_meta.special_val;
        r_mant             <= n_mant;
        r_rnd              <= n_rnd;
        r_product          <= n_product;
        r_ovf              <= n_ovf;
        r_unf              <= n_unf;
    end

    assign o_vld     = r_vld_d;
    assign o_product = r_product;
    assign o_ovf     = r_ovf;
    assign o_unf     = r_unf;

endmodule

// ===== design/double_precision_multiplier.sv =====
// ----------------------------------------------------------------------------
// double_precision_multiplier
// Pipelined IEEE-754 binary64 multiplier, round to nearest even, flush to zero.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is always low here, so a new operand pair may enter every cycle.
//   The product and its two flags appear on o_product, o_overflow_flag and
//   o_underflow_flag for exactly one cycle, marked by o_valid, once the
//   request has passed the stages below. Throughput is one product per cycle.
//   Stages: operand decode, partial products, product sum, normalize, and
//   round with pack. The 53x53 multiply is split into four products of at
//   most 27x27 bits, which sets the depth of the second and third stages.
//   The receiver cannot stall the result; it must take o_valid cycles as
//   they come. Reset clears all valid bits, so no result appears until a
//   request enters after reset. Payload registers are not cleared by reset.
// ----------------------------------------------------------------------------
module double_precision_multiplier
    import dpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_product,
    output logic              o_overflow_flag,
    output logic              o_underflow_flag
);

    logic              s1_vld, s3_vld;
    t_meta             s1_meta, s3_meta;
    logic [SIG_W-1:0]  s1_ma, s1_mb;
    logic [PROD_W-1:0] s3_prod;

    // The pipeline never stalls.
    assign busy = 1'b0;

    dpm_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_vld   (s1_vld),
        .o_meta  (s1_meta),
        .o_ma    (s1_ma),
        .o_mb    (s1_mb)
    );

    dpm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s1_vld),
        .i_meta  (s1_meta),
        .i_ma    (s1_ma),
        .i_mb    (s1_mb),
        .o_vld   (s3_vld),
        .o_meta  (s3_meta),
        .o_prod  (s3_prod)
    );

    dpm_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (s3_vld),
        .i_meta    (s3_meta),
        .i_prod    (s3_prod),
        .o_vld     (o_valid),
        .o_product (o_product),
        .o_ovf     (o_overflow_flag),
        .o_unf     (o_underflow_flag)
    );

    // Every request gives a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("request did not produce a result after five cycles");

    // Both range flags are never raised together.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow_flag && o_underflow_flag))
        else $error("overflow and underflow raised together");

    // Overflow always delivers infinity.
    a_ovf_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow_flag) |->
            (o_product[WORD_W-2 -: EXP_W] == EXP_MAX) && (o_product[FRAC_W-1:0] == '0))
        else $error("overflow result is not infinity");

    // Underflow always delivers a signed zero.
    a_unf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_underflow_flag) |-> (o_product[WORD_W-2:0] == '0))
        else $error("underflow result is not zero");

endmodule
